>>> rtl/mcptg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcptg_pkg
// shared types and constants of the multi-channel pulse train generator
// ----------------------------------------------------------------------------
package mcptg_pkg;

  // default configuration
  localparam int NumChannels = 4;
  localparam int CountWidth  = 16;

  // item kind codes
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindStop  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic [14:0] on_ticks;
    logic [14:0] off_ticks;
    logic [15:0] pulse_total;
    logic [15:0] delay_ticks;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [3:0] levels;
    logic [3:0] running;
  } out_item_t;

  // datapath operations
  typedef enum logic [1:0] {
    OpIdle,
    OpStart,
    OpStop,
    OpTick
  } dp_op_e;

  // controller to datapath command
  typedef struct packed {
    logic   capture;
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

endpackage

>>> rtl/mcptg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcptg_datapath
// per-channel counters, level and running flags, item and result registers
// ----------------------------------------------------------------------------
module mcptg_datapath #(
  parameter int NUM_CHANNELS = mcptg_pkg::NumChannels,
  parameter int COUNT_WIDTH  = mcptg_pkg::CountWidth,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcptg_pkg::dp_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]     chan_idx_i,
  input  mcptg_pkg::in_item_t  in_data_i,
  output mcptg_pkg::out_item_t out_data_o
);

  localparam int         PadW   = (NUM_CHANNELS > 4) ? NUM_CHANNELS : 4;
  localparam logic [32:0] CntMax = (33'd1 << COUNT_WIDTH) - 33'd1;

  mcptg_pkg::in_item_t  item_q;
  mcptg_pkg::out_item_t out_q;

  logic [NUM_CHANNELS-1:0] level_q;
  logic [NUM_CHANNELS-1:0] active_q;
  logic [COUNT_WIDTH-1:0]  delay_q  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  phase_q  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  period_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  pulses_q [NUM_CHANNELS];
  logic [14:0]             high_q   [NUM_CHANNELS];
  logic [14:0]             low_q    [NUM_CHANNELS];

  // start load values
  logic [IDX_W-1:0]       st_idx;
  logic                   st_ok;
  logic [15:0]            st_sum;
  logic [16:0]            st_total_inc;
  logic [COUNT_WIDTH-1:0] st_count;
  logic [COUNT_WIDTH-1:0] st_delay;

  always_comb begin
    st_idx       = IDX_W'(item_q.channel);
    st_ok        = 32'(item_q.channel) < 32'(NUM_CHANNELS);
    st_sum       = {1'b0, item_q.on_ticks} + {1'b0, item_q.off_ticks};
    st_total_inc = {1'b0, item_q.pulse_total} + 17'd1;
    st_delay     = COUNT_WIDTH'(item_q.delay_ticks);
    if (item_q.pulse_total == '0) begin
      st_count = COUNT_WIDTH'(1);
    end else if (33'(st_total_inc) > CntMax) begin
      st_count = COUNT_WIDTH'(CntMax);
    end else begin
      st_count = COUNT_WIDTH'(st_total_inc);
    end
  end

  // one tick of the visited channel
  logic [COUNT_WIDTH-1:0] t_delay;
  logic [COUNT_WIDTH-1:0] t_phase;
  logic [COUNT_WIDTH-1:0] t_period;
  logic [COUNT_WIDTH-1:0] t_pulses;
  logic                   t_level;
  logic                   t_active;
  logic [15:0]            t_sum;

  always_comb begin
    t_delay  = delay_q[chan_idx_i];
    t_phase  = phase_q[chan_idx_i];
    t_period = period_q[chan_idx_i];
    t_pulses = pulses_q[chan_idx_i];
    t_level  = level_q[chan_idx_i];
    t_active = active_q[chan_idx_i];
    t_sum    = {1'b0, high_q[chan_idx_i]} + {1'b0, low_q[chan_idx_i]};
    if (t_active) begin
      if (t_delay != '0 && high_q[chan_idx_i] != '0) begin
        // start delay counts down, pulse begins at zero
        t_delay = t_delay - COUNT_WIDTH'(1);
        if (t_delay == '0) begin
          t_level = 1'b1;
        end
      end else if (t_phase != '0) begin
        t_period = t_period - COUNT_WIDTH'(1);
        t_phase  = t_phase - COUNT_WIDTH'(1);
        if (t_phase == '0) begin
          if (t_period != '0) begin
            // high phase over, low phase begins
            t_phase = COUNT_WIDTH'(low_q[chan_idx_i]);
            t_level = 1'b0;
          end else begin
            // period over, count the pulse
            t_pulses = t_pulses - COUNT_WIDTH'(1);
            if (t_pulses > COUNT_WIDTH'(1)) begin
              t_period = COUNT_WIDTH'(t_sum);
              t_phase  = COUNT_WIDTH'(high_q[chan_idx_i]);
              t_level  = 1'b1;
            end else if (t_pulses == COUNT_WIDTH'(1)) begin
              t_level  = 1'b0;
              t_active = 1'b0;
            end else begin
              // endless train keeps the count at one
              t_period = COUNT_WIDTH'(t_sum);
              t_phase  = COUNT_WIDTH'(high_q[chan_idx_i]);
              t_level  = 1'b1;
              t_pulses = COUNT_WIDTH'(1);
            end
          end
        end
      end
    end
  end

  // flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      active_q <= '0;
    end else begin
      case (cmd_i.op)
        mcptg_pkg::OpStart: begin
          if (st_ok) begin
            active_q[st_idx] <= 1'b1;
            level_q[st_idx]  <= (st_delay == '0) && (item_q.on_ticks != '0);
          end
        end
        mcptg_pkg::OpStop: begin
          if (st_ok) begin
            active_q[st_idx] <= 1'b0;
            level_q[st_idx]  <= 1'b0;
          end
        end
        mcptg_pkg::OpTick: begin
          active_q[chan_idx_i] <= t_active;
          level_q[chan_idx_i]  <= t_level;
        end
        default: ;
      endcase
    end
  end

  // counters and item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    case (cmd_i.op)
      mcptg_pkg::OpStart: begin
        if (st_ok) begin
          high_q[st_idx]   <= item_q.on_ticks;
          low_q[st_idx]    <= item_q.off_ticks;
          delay_q[st_idx]  <= st_delay;
          phase_q[st_idx]  <= COUNT_WIDTH'(item_q.on_ticks);
          period_q[st_idx] <= COUNT_WIDTH'(st_sum);
          pulses_q[st_idx] <= st_count;
        end
      end
      mcptg_pkg::OpTick: begin
        delay_q[chan_idx_i]  <= t_delay;
        phase_q[chan_idx_i]  <= t_phase;
        period_q[chan_idx_i] <= t_period;
        pulses_q[chan_idx_i] <= t_pulses;
      end
      default: ;
    endcase
  end

  // result register
  logic [PadW-1:0] level_pad;
  logic [PadW-1:0] active_pad;

  assign level_pad  = PadW'(level_q);
  assign active_pad = PadW'(active_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.levels  <= level_pad[3:0];
      out_q.running <= active_pad[3:0];
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/mcptg_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcptg_controller
// sequences one item at a time and owns both handshakes
// ----------------------------------------------------------------------------
module mcptg_controller #(
  parameter int NUM_CHANNELS = mcptg_pkg::NumChannels,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcptg_pkg::dp_cmd_t cmd_o,
  output logic [IDX_W-1:0]   chan_idx_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_CHANNELS - 1);

  typedef enum logic [2:0] {
    SIdle,
    SStart,
    SStop,
    STick,
    SDone
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic             in_xfer;
  logic             out_free;

  assign in_ready_o = (state_q == SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // commands decoded from state
  always_comb begin
    cmd_o.capture  = in_xfer;
    cmd_o.load_out = (state_q == SDone) && out_free;
    case (state_q)
      SStart:  cmd_o.op = mcptg_pkg::OpStart;
      SStop:   cmd_o.op = mcptg_pkg::OpStop;
      STick:   cmd_o.op = mcptg_pkg::OpTick;
      default: cmd_o.op = mcptg_pkg::OpIdle;
    endcase
  end

  assign chan_idx_o  = idx_q;
  assign out_valid_o = out_valid_q;

  // state, channel counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_xfer) begin
            idx_q <= '0;
            case (in_kind_i)
              mcptg_pkg::KindTick:  state_q <= STick;
              mcptg_pkg::KindStart: state_q <= SStart;
              mcptg_pkg::KindStop:  state_q <= SStop;
              default:              state_q <= SDone;
            endcase
          end
        end
        SStart, SStop: begin
          state_q <= SDone;
        end
        STick: begin
          if (idx_q == LastIdx) begin
            state_q <= SDone;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        SDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  // result is loaded only into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  // an accepted item leaves idle at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != SIdle))
    else $error("accepted item not processed");

  // a tick sweep starts at the first channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_kind_i == mcptg_pkg::KindTick) |=> (state_q == STick && idx_q == '0))
    else $error("tick sweep does not start at channel zero");

  // sweep never visits a channel beyond the last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == STick) |-> (32'(idx_q) < 32'(NUM_CHANNELS)))
    else $error("channel index out of range");

  // a finished item always raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_q && state_q == SIdle))
    else $error("result valid not raised");

endmodule

>>> rtl/multi_channel_pulse_train_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_pulse_train_generator_unit
// per-channel pulse trains with start delay, on/off phases and pulse count
// ----------------------------------------------------------------------------
// Each item (tick, start or stop) returns one result with the channel levels
// and running mask as they stand after the item. Items are handled one at a
// time: a start or stop goes through its state and then the done state; a
// tick has the controller sweep the channels through one shared tick unit,
// one channel per cycle in the tick state, then the done state. A new item is
// taken while the previous result still waits on the output register.
module multi_channel_pulse_train_generator_unit #(
  parameter int NUM_CHANNELS = mcptg_pkg::NumChannels,
  parameter int COUNT_WIDTH  = mcptg_pkg::CountWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcptg_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcptg_pkg::out_item_t out_data_o
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  mcptg_pkg::dp_cmd_t cmd;
  logic [IdxW-1:0]    chan_idx;

  // sequencer
  mcptg_controller #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IdxW)
  ) u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_data_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .chan_idx_o  (chan_idx)
  );

  // channel state and result register
  mcptg_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .IDX_W        (IdxW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .chan_idx_i (chan_idx),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
